// File: rtl/cru_pkg.sv
// types and command codes shared by the condition register unit
`timescale 1ns / 1ps

package cru_pkg;

   // instruction codes carried in the cmd field
   typedef enum logic [3:0] {
      CMD_CMP    = 4'd0,
      CMD_CMPI   = 4'd1,
      CMD_CMPL   = 4'd2,
      CMD_CMPLI  = 4'd3,
      CMD_CRAND  = 4'd4,
      CMD_CRANDC = 4'd5,
      CMD_CREQV  = 4'd6,
      CMD_CRNAND = 4'd7,
      CMD_CRNOR  = 4'd8,
      CMD_CROR   = 4'd9,
      CMD_CRORC  = 4'd10,
      CMD_CRXOR  = 4'd11,
      CMD_MCRF   = 4'd12,
      CMD_MCRXR  = 4'd13,
      CMD_MFCR   = 4'd14,
      CMD_MTCRF  = 4'd15
   } cru_cmd_type;

   // condition field bit weights
   localparam logic [3:0] CR_LT = 4'b1000;
   localparam logic [3:0] CR_GT = 4'b0100;
   localparam logic [3:0] CR_EQ = 4'b0010;

   // request transaction
   typedef struct packed {
      cru_cmd_type cmd;
      logic [2:0]  field_dest;
      logic [2:0]  field_src;
      logic [4:0]  bit_dest;
      logic [4:0]  bit_a;
      logic [4:0]  bit_b;
      logic [31:0] reg_a;
      logic [31:0] reg_b;
      logic [15:0] imm;
      logic [7:0]  field_mask;
      logic [3:0]  xer_flags;
   } cru_req_type;

   // response transaction
   typedef struct packed {
      logic [31:0] cr_value;
      logic [31:0] gpr_value;
      logic        gpr_write;
      logic [3:0]  xer_flags_out;
      logic        xer_write;
   } cru_rsp_type;

endpackage

// File: rtl/condition_register_unit.sv
// condition register unit: compares, cr bit logic and cr field moves
// path: a request is held in the input register, then in the output register, where rsp_valid rises
// throughput: one transaction per cycle unless rsp_stall holds the output; the cr update is one
// level of logic between the input register and the output register, fed back directly
// reset: synchronous, active high; clears the condition register and both valid flags
`timescale 1ns / 1ps

module condition_register_unit
   import cru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cru_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cru_rsp_type rsp_data
);

   logic        req_valid_ff, req_valid_in;
   cru_req_type req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   cru_rsp_type rsp_ff, rsp_in;
   logic [31:0] cr_ff, cr_in;
   logic        out_free;
   logic        advance;
   logic        take;

   // handshake control
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = req_valid_ff && out_free;
   assign req_stall    = req_valid_ff && !out_free;
   assign take         = req_valid && !req_stall;
   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // instruction execution
   always_comb begin
      logic [31:0] b_val;
      logic        lt;
      logic        gt;
      logic [3:0]  nib;
      logic        bit_a;
      logic        bit_b;
      logic        bit_r;
      logic [4:0]  dest_lsb;
      logic [4:0]  src_lsb;
      cr_in                = cr_ff;
      rsp_in.gpr_value     = '0;
      rsp_in.gpr_write     = 1'b0;
      rsp_in.xer_flags_out = req_ff.xer_flags;
      rsp_in.xer_write     = 1'b0;
      dest_lsb             = {~req_ff.field_dest, 2'b00};
      src_lsb              = {~req_ff.field_src, 2'b00};
      bit_a                = cr_ff[~req_ff.bit_a];
      bit_b                = cr_ff[~req_ff.bit_b];

      // second compare operand
      unique case (req_ff.cmd)
         CMD_CMPI:  b_val = {{16{req_ff.imm[15]}}, req_ff.imm};
         CMD_CMPLI: b_val = {16'h0000, req_ff.imm};
         default:   b_val = req_ff.reg_b;
      endcase

      // signed or unsigned order
      if (req_ff.cmd == CMD_CMP || req_ff.cmd == CMD_CMPI) begin
         lt = $signed(req_ff.reg_a) < $signed(b_val);
         gt = $signed(req_ff.reg_a) > $signed(b_val);
      end else begin
         lt = req_ff.reg_a < b_val;
         gt = req_ff.reg_a > b_val;
      end
      nib = lt ? CR_LT : (gt ? CR_GT : CR_EQ);
      nib[0] = req_ff.xer_flags[3];

      // cr bit logic
      unique case (req_ff.cmd)
         CMD_CRAND:  bit_r = bit_a & bit_b;
         CMD_CRANDC: bit_r = bit_a & ~bit_b;
         CMD_CREQV:  bit_r = ~(bit_a ^ bit_b);
         CMD_CRNAND: bit_r = ~(bit_a & bit_b);
         CMD_CRNOR:  bit_r = ~(bit_a | bit_b);
         CMD_CROR:   bit_r = bit_a | bit_b;
         CMD_CRORC:  bit_r = bit_a | ~bit_b;
         default:    bit_r = bit_a ^ bit_b;
      endcase

      // cr update per instruction
      unique case (req_ff.cmd)
         CMD_CMP, CMD_CMPI, CMD_CMPL, CMD_CMPLI: begin
            cr_in[dest_lsb +: 4] = nib;
         end
         CMD_CRAND, CMD_CRANDC, CMD_CREQV, CMD_CRNAND,
         CMD_CRNOR, CMD_CROR, CMD_CRORC, CMD_CRXOR: begin
            cr_in[~req_ff.bit_dest] = bit_r;
         end
         CMD_MCRF: begin
            cr_in[dest_lsb +: 4] = cr_ff[src_lsb +: 4];
         end
         CMD_MCRXR: begin
            cr_in[dest_lsb +: 4] = req_ff.xer_flags;
            rsp_in.xer_flags_out = '0;
            rsp_in.xer_write     = 1'b1;
         end
         CMD_MFCR: begin
            rsp_in.gpr_value = cr_ff;
            rsp_in.gpr_write = 1'b1;
         end
         CMD_MTCRF: begin
            for (int i = 0; i < 8; i++) begin
               if (req_ff.field_mask[i]) begin
                  cr_in[i*4 +: 4] = req_ff.reg_a[i*4 +: 4];
               end
            end
         end
         default: begin
            cr_in = cr_ff;
         end
      endcase
      rsp_in.cr_value = cr_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cr_ff        <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            cr_ff <= cr_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // reset clears the condition register
   a_reset_cr: assert property (@(posedge clock) reset |=> cr_ff == '0)
      else $error("cr not cleared by reset");

   // cr holds while a response is stalled
   a_cr_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(cr_ff))
      else $error("cr changed while response stalled");

   // mfcr returns the unchanged cr
   a_mfcr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gpr_write |-> rsp_data.gpr_value == rsp_data.cr_value)
      else $error("mfcr value differs from cr");

   // mcrxr clears the xer flags and never writes a gpr
   a_mcrxr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.xer_write |->
         rsp_data.xer_flags_out == 4'h0 && !rsp_data.gpr_write)
      else $error("bad mcrxr response");

endmodule

// File: test/tb.sv
// self-checking testbench for the condition register unit
`timescale 1ns / 1ps

module tb;
   import cru_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cru_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cru_rsp_type rsp_data;

   // instructions waiting to be driven, responses predicted at accept time
   cru_req_type pending_instr[$];
   cru_rsp_type expected_cr_rsp[$];
   logic [31:0] cr_shadow = '0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatches = 0;

   condition_register_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 50 MHz clock
   always #10 clock = ~clock;

   // executes one instruction against the shadow condition register
   function automatic cru_rsp_type execute_instr(cru_req_type r);
      cru_rsp_type rsp;
      logic [31:0] cr;
      logic [31:0] rhs;
      logic [3:0]  nib;
      logic        put;
      logic        is_lt;
      logic        is_gt;
      logic        a;
      logic        b;
      logic        res;
      cr = cr_shadow;
      rsp = '0;
      rsp.xer_flags_out = r.xer_flags;
      put = 1'b0;
      nib = '0;
      case (r.cmd)
         CMD_CMP, CMD_CMPI, CMD_CMPL, CMD_CMPLI: begin
            if (r.cmd == CMD_CMP || r.cmd == CMD_CMPL)
               rhs = r.reg_b;
            else if (r.cmd == CMD_CMPI)
               rhs = {{16{r.imm[15]}}, r.imm};
            else
               rhs = {16'd0, r.imm};
            if (r.cmd == CMD_CMP || r.cmd == CMD_CMPI) begin
               is_lt = $signed(r.reg_a) < $signed(rhs);
               is_gt = $signed(r.reg_a) > $signed(rhs);
            end else begin
               is_lt = r.reg_a < rhs;
               is_gt = r.reg_a > rhs;
            end
            // summary overflow lands in the lowest bit of the field
            nib = {3'b000, r.xer_flags[3]} | (is_lt ? CR_LT : (is_gt ? CR_GT : CR_EQ));
            put = 1'b1;
         end
         CMD_CRAND, CMD_CRANDC, CMD_CREQV, CMD_CRNAND,
         CMD_CRNOR, CMD_CROR, CMD_CRORC, CMD_CRXOR: begin
            a = cr[31 - r.bit_a];
            b = cr[31 - r.bit_b];
            case (r.cmd)
               CMD_CRAND:  res = a & b;
               CMD_CRANDC: res = a & ~b;
               CMD_CREQV:  res = ~(a ^ b);
               CMD_CRNAND: res = ~(a & b);
               CMD_CRNOR:  res = ~(a | b);
               CMD_CROR:   res = a | b;
               CMD_CRORC:  res = a | ~b;
               default:    res = a ^ b;
            endcase
            cr[31 - r.bit_dest] = res;
         end
         CMD_MCRF: begin
            nib = cr[(7 - r.field_src) * 4 +: 4];
            put = 1'b1;
         end
         CMD_MCRXR: begin
            nib = r.xer_flags;
            put = 1'b1;
            rsp.xer_flags_out = '0;
            rsp.xer_write = 1'b1;
         end
         CMD_MFCR: begin
            rsp.gpr_value = cr;
            rsp.gpr_write = 1'b1;
         end
         default: begin
            for (int i = 0; i < 8; i++)
               if (r.field_mask[i])
                  cr[i * 4 +: 4] = r.reg_a[i * 4 +: 4];
         end
      endcase
      // field 0 is the most significant nibble
      if (put)
         cr[(7 - r.field_dest) * 4 +: 4] = nib;
      cr_shadow = cr;
      rsp.cr_value = cr;
      return rsp;
   endfunction

   function automatic cru_req_type make_instr(cru_cmd_type cmd, logic [31:0] ra,
                                              logic [31:0] rb, logic [15:0] imm,
                                              logic [2:0] fd, logic [2:0] fs,
                                              logic [4:0] bd, logic [4:0] ba,
                                              logic [4:0] bb, logic [7:0] mask,
                                              logic [3:0] xer);
      cru_req_type it;
      it = '0;
      it.cmd = cmd;
      it.reg_a = ra;
      it.reg_b = rb;
      it.imm = imm;
      it.field_dest = fd;
      it.field_src = fs;
      it.bit_dest = bd;
      it.bit_a = ba;
      it.bit_b = bb;
      it.field_mask = mask;
      it.xer_flags = xer;
      return it;
   endfunction

   // random instruction with a bias toward equal and boundary operands
   function automatic cru_req_type random_instr();
      cru_req_type it;
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(cru_req_type)-1:0];
      case ($urandom_range(7))
         0: it.reg_b = it.reg_a;
         1: it.reg_a = {{16{it.imm[15]}}, it.imm};
         2: it.reg_a = {16'd0, it.imm};
         3: begin
            it.reg_a = $urandom_range(3);
            it.reg_b = $urandom_range(3);
         end
         4: begin
            it.bit_b = it.bit_a;
            it.bit_dest = it.bit_a;
         end
         5: it.field_src = it.field_dest;
         default: ;
      endcase
      return it;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s expected %h got %h", $realtime, what, want, got);
   endtask

   // driver: predicts on accept, then presents the next instruction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_cr_rsp.push_back(execute_instr(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_instr.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_instr.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response transaction against the oldest prediction
   always @(posedge clock) begin : monitor
      cru_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cr_rsp.size() == 0) begin
               note_mismatch("unexpected response, cr_value", '0, rsp_data.cr_value);
            end else begin
               want = expected_cr_rsp.pop_front();
               if (rsp_data.cr_value !== want.cr_value)
                  note_mismatch("cr_value", want.cr_value, rsp_data.cr_value);
               if (rsp_data.gpr_value !== want.gpr_value)
                  note_mismatch("gpr_value", want.gpr_value, rsp_data.gpr_value);
               if (rsp_data.gpr_write !== want.gpr_write)
                  note_mismatch("gpr_write", 32'(want.gpr_write),
                                32'(rsp_data.gpr_write));
               if (rsp_data.xer_flags_out !== want.xer_flags_out)
                  note_mismatch("xer_flags_out", 32'(want.xer_flags_out),
                                32'(rsp_data.xer_flags_out));
               if (rsp_data.xer_write !== want.xer_write)
                  note_mismatch("xer_write", 32'(want.xer_write),
                                32'(rsp_data.xer_write));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // stimulus: directed instructions, then random phases with varying idling and stalling
   initial begin : stimulus
      int idle_plan[4];
      int stall_plan[4];
      idle_plan = '{0, 62, 0, 25};
      stall_plan = '{0, 0, 62, 25};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill, read back, empty mask, partial mask
      pending_instr.push_back(make_instr(CMD_MTCRF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 0));
      pending_instr.push_back(make_instr(CMD_MFCR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_instr.push_back(make_instr(CMD_MTCRF, 32'h0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      pending_instr.push_back(make_instr(CMD_MTCRF, 32'h12345678, 0, 0, 0, 0, 0, 0, 0, 8'h81, 0));
      // signed versus unsigned order at the sign boundary
      pending_instr.push_back(make_instr(CMD_CMP, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0,
                                         0, 4'b1000));
      pending_instr.push_back(make_instr(CMD_CMPL, 32'h80000000, 32'h7FFFFFFF, 0, 7, 0, 0, 0, 0,
                                         0, 4'b0111));
      pending_instr.push_back(make_instr(CMD_CMP, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 3, 0, 0, 0, 0,
                                         0, 4'b1111));
      // immediate extension
      pending_instr.push_back(make_instr(CMD_CMPI, 32'hFFFFFFFF, 0, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0));
      pending_instr.push_back(make_instr(CMD_CMPLI, 32'hFFFFFFFF, 0, 16'hFFFF, 2, 0, 0, 0, 0, 0,
                                         4'b1000));
      pending_instr.push_back(make_instr(CMD_CMPI, 32'h0, 0, 16'h8000, 4, 0, 0, 0, 0, 0, 0));
      pending_instr.push_back(make_instr(CMD_CMPLI, 32'h0, 0, 16'h8000, 5, 0, 0, 0, 0, 0, 0));
      // every bit logic operation, extreme bit numbers
      pending_instr.push_back(make_instr(CMD_CRAND, 0, 0, 0, 0, 0, 0, 0, 31, 0, 0));
      pending_instr.push_back(make_instr(CMD_CRANDC, 0, 0, 0, 0, 0, 31, 0, 31, 0, 0));
      pending_instr.push_back(make_instr(CMD_CREQV, 0, 0, 0, 0, 0, 15, 31, 0, 0, 0));
      pending_instr.push_back(make_instr(CMD_CRNAND, 0, 0, 0, 0, 0, 0, 31, 31, 0, 0));
      pending_instr.push_back(make_instr(CMD_CRNOR, 0, 0, 0, 0, 0, 31, 1, 2, 0, 0));
      pending_instr.push_back(make_instr(CMD_CROR, 0, 0, 0, 0, 0, 16, 0, 31, 0, 0));
      pending_instr.push_back(make_instr(CMD_CRORC, 0, 0, 0, 0, 0, 5, 5, 5, 0, 0));
      pending_instr.push_back(make_instr(CMD_CRXOR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // field moves, including a move onto itself
      pending_instr.push_back(make_instr(CMD_MCRF, 0, 0, 0, 7, 0, 0, 0, 0, 0, 0));
      pending_instr.push_back(make_instr(CMD_MCRF, 0, 0, 0, 3, 3, 0, 0, 0, 0, 0));
      pending_instr.push_back(make_instr(CMD_MCRXR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4'b1111));
      pending_instr.push_back(make_instr(CMD_MCRXR, 0, 0, 0, 7, 0, 0, 0, 0, 0, 4'b0000));
      pending_instr.push_back(make_instr(CMD_MFCR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      while (pending_instr.size() != 0)
         @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         recv_stall_pct = stall_plan[p];
         repeat (400)
            pending_instr.push_back(random_instr());
         while (pending_instr.size() != 0)
            @(negedge clock);
      end

      // drain, then leave room for a stray response
      while (req_valid || expected_cr_rsp.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
